>>> rtl/character_stream_lexer_unit_macros.svh
// Assertion macros shared by the lexer RTL files.
// No dependencies; included by the front end, the queue and the back end.
`ifndef CHARACTER_STREAM_LEXER_UNIT_MACROS_SVH
`define CHARACTER_STREAM_LEXER_UNIT_MACROS_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define CSL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent in a cycle implies consequent in the next.
`define CSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define CSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/csl_pkg.sv
// Shared constants, codes and the result plan type for the character lexer.
// No dependencies; imported by every lexer module.
package csl_pkg;

    localparam int FifoDepthDefault = 4;

    // Lexer modes.
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_WORD   = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_SQ     = 3'd3;
    localparam logic [2:0] MODE_DQ     = 3'd4;
    localparam logic [2:0] MODE_BQ     = 3'd5;

    // Token classes.
    localparam logic [2:0] CLS_WORD    = 3'd0;
    localparam logic [2:0] CLS_NUMBER  = 3'd1;
    localparam logic [2:0] CLS_ARITH   = 3'd2;
    localparam logic [2:0] CLS_BRACKET = 3'd3;
    localparam logic [2:0] CLS_SQ      = 3'd4;
    localparam logic [2:0] CLS_DQ      = 3'd5;
    localparam logic [2:0] CLS_BQ      = 3'd6;

    // Result kinds.
    localparam logic RK_CHAR = 1'b0;
    localparam logic RK_END  = 1'b1;

    // Input kinds.
    localparam logic IK_CHAR = 1'b0;
    localparam logic IK_EOF  = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Up to three results for one input item, always in this order:
    // closing marker of a pending token, the character, a trailing marker.
    typedef struct packed {
        logic       has_close;
        logic [2:0] close_cls;
        logic       has_char;
        logic [7:0] ch;
        logic [2:0] cls;
        logic       first;
        logic       has_end;
    } t_plan;

endpackage

>>> rtl/csl_front.sv
// Front end of the lexer: classifies each input item and keeps the lexer state.
// Depends on csl_pkg and the assertion macro header.
`include "character_stream_lexer_unit_macros.svh"
module csl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_kind,
    input  logic [7:0]     i_char,
    output logic           o_push,
    output csl_pkg::t_plan o_plan
);
    import csl_pkg::*;

    logic [2:0] r_mode;
    logic [2:0] n_mode;
    logic       r_prev_bs;
    logic       n_prev_bs;
    logic [2:0] mode;
    logic       pend;
    logic [2:0] pend_cls;
    logic [7:0] quote_ch;
    logic       is_ws;
    logic       is_quote;
    logic       is_num;
    logic       is_arith;
    logic       is_brack;
    t_plan      plan;

    always_comb begin
        mode     = (r_mode > MODE_BQ) ? MODE_IDLE : r_mode;
        pend     = (mode == MODE_WORD) || (mode == MODE_NUMBER);
        pend_cls = (mode == MODE_WORD) ? CLS_WORD : CLS_NUMBER;
        quote_ch = (mode == MODE_SQ) ? CH_SQUOTE : (mode == MODE_DQ) ? CH_DQUOTE : CH_BTICK;
        is_ws    = (i_char == CH_SPACE) || (i_char == CH_LF) || (i_char == CH_CR);
        is_quote = (i_char == CH_SQUOTE) || (i_char == CH_DQUOTE) || (i_char == CH_BTICK);
        is_num   = ((i_char >= CH_ZERO) && (i_char <= CH_NINE)) || (i_char == CH_DOT);
        is_arith = (i_char == CH_PLUS) || (i_char == CH_MINUS) || (i_char == CH_STAR) ||
                   (i_char == CH_SLASH) || (i_char == CH_EQUAL);
        is_brack = (i_char == CH_LT) || (i_char == CH_GT) || (i_char == CH_LPAR) ||
                   (i_char == CH_RPAR) || (i_char == CH_LBRACE) || (i_char == CH_RBRACE) ||
                   (i_char == CH_LBRACK) || (i_char == CH_RBRACK);

        plan      = '0;
        plan.ch   = i_char;
        n_mode    = mode;
        n_prev_bs = r_prev_bs;

        if (i_kind == IK_EOF) begin
            // The closing class is the mode code less one, quotes included.
            plan.has_close = (mode != MODE_IDLE);
            plan.close_cls = mode - 3'd1;
            n_mode         = MODE_IDLE;
            n_prev_bs      = 1'b0;
        end else if (mode >= MODE_SQ) begin
            plan.has_char = 1'b1;
            plan.cls      = mode + 3'd1;
            if ((i_char == quote_ch) && !r_prev_bs) begin
                plan.has_end = 1'b1;
                n_mode       = MODE_IDLE;
                n_prev_bs    = 1'b0;
            end else begin
                n_prev_bs = (i_char == CH_BSLASH);
            end
        end else if (is_ws) begin
            plan.has_close = pend;
            plan.close_cls = pend_cls;
            n_mode         = MODE_IDLE;
        end else if (is_quote) begin
            plan.has_close = pend;
            plan.close_cls = pend_cls;
            plan.has_char  = 1'b1;
            plan.first     = 1'b1;
            if (i_char == CH_SQUOTE) begin
                n_mode   = MODE_SQ;
                plan.cls = CLS_SQ;
            end else if (i_char == CH_DQUOTE) begin
                n_mode   = MODE_DQ;
                plan.cls = CLS_DQ;
            end else begin
                n_mode   = MODE_BQ;
                plan.cls = CLS_BQ;
            end
            n_prev_bs = 1'b0;
        end else if (is_num) begin
            plan.has_char = 1'b1;
            plan.cls      = CLS_NUMBER;
            if (mode != MODE_NUMBER) begin
                plan.has_close = pend;
                plan.close_cls = pend_cls;
                plan.first     = 1'b1;
                n_mode         = MODE_NUMBER;
            end
        end else if (is_arith || is_brack) begin
            plan.has_close = pend;
            plan.close_cls = pend_cls;
            plan.has_char  = 1'b1;
            plan.cls       = is_arith ? CLS_ARITH : CLS_BRACKET;
            plan.first     = 1'b1;
            plan.has_end   = 1'b1;
            n_mode         = MODE_IDLE;
        end else begin
            plan.has_char = 1'b1;
            plan.cls      = CLS_WORD;
            if (mode != MODE_WORD) begin
                plan.has_close = pend;
                plan.close_cls = pend_cls;
                plan.first     = 1'b1;
                n_mode         = MODE_WORD;
            end
        end
    end

    assign o_plan = plan;
    assign o_push = i_accept && (plan.has_close || plan.has_char || plan.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_prev_bs <= 1'b0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_prev_bs <= n_prev_bs;
        end
    end

    `CSL_ASSERT_ALWAYS(a_bs_only_in_quote, i_clk, i_rst_n, (r_mode >= MODE_SQ) || !r_prev_bs, "backslash flag set outside a quote")
    `CSL_ASSERT_NEXT(a_eof_idles, i_clk, i_rst_n, i_accept && (i_kind == IK_EOF), (r_mode == MODE_IDLE) && !r_prev_bs, "end of input did not return to idle")

endmodule

>>> rtl/csl_queue.sv
// Short queue of result plans between the lexer front end and back end.
// Depends on csl_pkg and the assertion macro header.
`include "character_stream_lexer_unit_macros.svh"
module csl_queue #(
    parameter int Depth = csl_pkg::FifoDepthDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csl_pkg::t_plan i_plan,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output csl_pkg::t_plan o_head
);
    import csl_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_plan           r_slot [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;

    assign o_full     = (r_count == CntFull);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
            end
            r_count <= n_count;
        end
    end

    `CSL_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into a full queue")
    `CSL_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_nonempty), "pop from an empty queue")

endmodule

>>> rtl/csl_back.sv
// Back end of the lexer: expands each plan into result items, one per cycle while the output is accepted.
// Depends on csl_pkg and the assertion macro header.
`include "character_stream_lexer_unit_macros.svh"
module csl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_nonempty,
    input  csl_pkg::t_plan i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [7:0]     o_char,
    output logic [2:0]     o_cls,
    output logic           o_first,
    output logic           o_last
);
    import csl_pkg::*;

    t_plan      r_pend;
    logic       r_busy;
    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_char;
    logic [2:0] r_cls;
    logic       r_first;
    logic       r_last;
    t_plan      src;
    t_plan      rem;
    logic       out_free;
    logic       emit;
    logic       n_kind;
    logic [7:0] n_char;
    logic [2:0] n_cls;
    logic       n_first;

    assign out_free = !r_valid || i_ready;
    assign emit     = out_free && (r_busy || i_nonempty);
    assign o_pop    = out_free && !r_busy && i_nonempty;

    always_comb begin
        src     = r_busy ? r_pend : i_head;
        rem     = src;
        n_kind  = RK_END;
        n_char  = '0;
        n_cls   = src.cls;
        n_first = 1'b0;
        if (src.has_close) begin
            n_cls         = src.close_cls;
            rem.has_close = 1'b0;
        end else if (src.has_char) begin
            n_kind       = RK_CHAR;
            n_char       = src.ch;
            n_first      = src.first;
            rem.has_char = 1'b0;
        end else begin
            rem.has_end = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pend  <= rem;
            r_kind  <= n_kind;
            r_char  <= n_char;
            r_cls   <= n_cls;
            r_first <= n_first;
            r_last  <= !(rem.has_close || rem.has_char || rem.has_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_busy  <= rem.has_close || rem.has_char || rem.has_end;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_char  = r_char;
    assign o_cls   = r_cls;
    assign o_first = r_first;
    assign o_last  = r_last;

    `CSL_ASSERT_ALWAYS(a_more_follows, i_clk, i_rst_n, !(r_valid && !r_last) || r_busy, "non-final result with nothing left to send")

endmodule

>>> rtl/character_stream_lexer_unit.sv
// Character stream lexer: accepts one input item per cycle while the result queue has room.
// Each item yields zero to three result items; results leave at one per cycle while the
// output is ready. The accepting edge writes the item's plan into the queue; the back end
// then loads its first result into its output register once that register is free.
// Synchronous active-low reset returns the lexer to idle and empties queue and output.
// Depends on csl_pkg, csl_front, csl_queue, csl_back and macros.
module character_stream_lexer_unit #(
    parameter int FifoDepth = csl_pkg::FifoDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input items.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic [0:0] i_s_axis_tuser,   // [0] kind: 0 character, 1 end of input
    // Result items.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_out
    output logic [4:0] o_m_axis_tuser,   // [0] result_kind, [3:1] token_class, [4] token_first
    output logic       o_m_axis_tlast    // final result caused by one input item
);
    import csl_pkg::*;

    // The front end works out, in the cycle an item is accepted, every result
    // that the item causes and stores them as a single plan in the queue. The
    // lexer state therefore moves on at full input rate while the queue has room, and
    // the back end is left to spread each plan over as many output cycles as it needs.
    logic       in_accept;
    logic       push;
    t_plan      push_plan;
    logic       q_full;
    logic       q_nonempty;
    logic       pop;
    t_plan      head;
    logic       res_kind;
    logic [2:0] res_cls;
    logic       res_first;

    // Ready depends only on the registered fill level of the queue, so there
    // is no combinational path from the output ready back to the input.
    assign o_s_axis_tready = !q_full;
    assign in_accept       = i_s_axis_tvalid && !q_full;

    csl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_kind   (i_s_axis_tuser[0]),
        .i_char   (i_s_axis_tdata),
        .o_push   (push),
        .o_plan   (push_plan)
    );

    csl_queue #(
        .Depth (FifoDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_plan     (push_plan),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    // The back end holds the plan it is working through and feeds a
    // registered output stage, which it reloads in the same cycle that the
    // previous result is taken.
    csl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_kind     (res_kind),
        .o_char     (o_m_axis_tdata),
        .o_cls      (res_cls),
        .o_first    (res_first),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {res_first, res_cls, res_kind};

endmodule

>>> verif/csl_token_checker.sv
// Result checker for the character stream lexer: predicts the token items for every
// accepted input item and compares each accepted result item against the oldest one due.
// Depends on csl_pkg for mode, class, kind and character codes.
module csl_token_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,    // [7:0] char_in
    input  logic [0:0] i_in_user,    // [0] kind
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_res_data,   // [7:0] char_out
    input  logic [4:0] i_res_user,   // [0] result_kind, [3:1] token_class, [4] token_first
    input  logic       i_res_last,
    output int         o_fail_count,
    output int         o_results_due
);
    import csl_pkg::*;

    typedef struct packed {
        logic       rk;
        logic [7:0] ch;
        logic [2:0] cls;
        logic       first;
        logic       last;
    } t_token_res;

    logic [2:0] lex_mode  = MODE_IDLE;
    logic       in_escape = 1'b0;
    t_token_res step_results[$];
    t_token_res tokens_due[$];
    int         mismatches = 0;

    function bit is_arith_char(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_EQUAL;
    endfunction

    function bit is_bracket_char(input logic [7:0] c);
        return c == CH_LT || c == CH_GT || c == CH_LPAR || c == CH_RPAR ||
               c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK || c == CH_RBRACK;
    endfunction

    task put_result(input logic rk, input logic [7:0] ch, input logic [2:0] cls,
                    input logic first);
        t_token_res r;
        r.rk    = rk;
        r.ch    = ch;
        r.cls   = cls;
        r.first = first;
        r.last  = 1'b0;
        step_results.insert(step_results.size(), r);
    endtask

    // A pending word or number gets its end marker; quotes are never closed here.
    task close_open_token;
        if (lex_mode == MODE_WORD) begin
            put_result(RK_END, 8'h00, CLS_WORD, 1'b0);
        end else if (lex_mode == MODE_NUMBER) begin
            put_result(RK_END, 8'h00, CLS_NUMBER, 1'b0);
        end
        lex_mode = MODE_IDLE;
    endtask

    task tokenise_item(input logic kind, input logic [7:0] c);
        logic [2:0] qcls;
        logic [7:0] qch;
        t_token_res r;
        step_results.delete();
        if (lex_mode > MODE_BQ) lex_mode = MODE_IDLE;
        if (kind == IK_EOF) begin
            if (lex_mode != MODE_IDLE) put_result(RK_END, 8'h00, lex_mode - 3'd1, 1'b0);
            lex_mode  = MODE_IDLE;
            in_escape = 1'b0;
        end else if (lex_mode >= MODE_SQ) begin
            qcls = lex_mode + 3'd1;
            qch  = (lex_mode == MODE_SQ) ? CH_SQUOTE :
                   (lex_mode == MODE_DQ) ? CH_DQUOTE : CH_BTICK;
            put_result(RK_CHAR, c, qcls, 1'b0);
            if (c == qch && !in_escape) begin
                put_result(RK_END, 8'h00, qcls, 1'b0);
                lex_mode  = MODE_IDLE;
                in_escape = 1'b0;
            end else begin
                in_escape = (c == CH_BSLASH);
            end
        end else if (c == CH_SPACE || c == CH_LF || c == CH_CR) begin
            close_open_token();
        end else if (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BTICK) begin
            close_open_token();
            lex_mode = (c == CH_SQUOTE) ? MODE_SQ : (c == CH_DQUOTE) ? MODE_DQ : MODE_BQ;
            put_result(RK_CHAR, c, lex_mode + 3'd1, 1'b1);
            in_escape = 1'b0;
        end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT) begin
            if (lex_mode == MODE_NUMBER) begin
                put_result(RK_CHAR, c, CLS_NUMBER, 1'b0);
            end else begin
                close_open_token();
                put_result(RK_CHAR, c, CLS_NUMBER, 1'b1);
                lex_mode = MODE_NUMBER;
            end
        end else if (is_arith_char(c) || is_bracket_char(c)) begin
            qcls = is_arith_char(c) ? CLS_ARITH : CLS_BRACKET;
            close_open_token();
            put_result(RK_CHAR, c, qcls, 1'b1);
            put_result(RK_END, 8'h00, qcls, 1'b0);
        end else begin
            if (lex_mode == MODE_WORD) begin
                put_result(RK_CHAR, c, CLS_WORD, 1'b0);
            end else begin
                close_open_token();
                put_result(RK_CHAR, c, CLS_WORD, 1'b1);
                lex_mode = MODE_WORD;
            end
        end
        if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.insert(step_results.size(), r);
        end
        foreach (step_results[i]) tokens_due.insert(tokens_due.size(), step_results[i]);
    endtask

    // Results are checked before the same edge's input is predicted: a result can never
    // belong to an item accepted at the same edge.
    always @(posedge i_clk) begin : watch
        t_token_res want;
        t_token_res got;
        if (!i_rst_n) begin
            lex_mode  = MODE_IDLE;
            in_escape = 1'b0;
            tokens_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = {i_res_user[0], i_res_data, i_res_user[3:1], i_res_user[4], i_res_last};
                if (tokens_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: kind=%0d char=%02h class=%0d",
                                 got.rk, got.ch, got.cls,
                                 " first=%0d last=%0d", got.first, got.last);
                    mismatches++;
                end else begin
                    want = tokens_due.pop_front();
                    if (got.rk !== want.rk || got.ch !== want.ch || got.cls !== want.cls ||
                        got.first !== want.first || got.last !== want.last) begin
                        if (mismatches < 10)
                            $display("result mismatch: expected kind=%0d char=%02h",
                                     want.rk, want.ch,
                                     " class=%0d first=%0d last=%0d,",
                                     want.cls, want.first, want.last,
                                     " got kind=%0d char=%02h class=%0d",
                                     got.rk, got.ch, got.cls,
                                     " first=%0d last=%0d", got.first, got.last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) tokenise_item(i_in_user[0], i_in_data);
        end
        o_fail_count  <= mismatches;
        o_results_due <= tokens_due.size();
    end

endmodule

>>> verif/character_stream_lexer_unit_tb.sv
// Top of the lexer testbench: clock, reset, stimulus and the final verdict.
// Depends on csl_pkg, the lexer RTL and csl_token_checker, which does all the checking.
module character_stream_lexer_unit_tb;
    import csl_pkg::*;

    localparam int RandomItems = 500;
    localparam int IdlePercent = 8;
    // The limit leaves ample headroom over the slowest correct run.
    localparam int CycleLimit  = 60000;
    // Drain run after the last due result has been taken.
    localparam int DrainCycles = 16;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data  = 8'h00;
    logic [0:0] s_user  = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_data;
    logic [4:0] m_user;
    logic       m_last;
    int         fail_count;
    int         results_due;
    int         cycle_count = 0;
    // Every input item as {kind, byte}, built in full before the first one is sent.
    logic [8:0] char_items[$];

    always #1 i_clk = ~i_clk;

    character_stream_lexer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    csl_token_checker token_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_valid),
        .i_in_ready    (s_ready),
        .i_in_data     (s_data),
        .i_in_user     (s_user),
        .i_res_valid   (m_valid),
        .i_res_ready   (m_ready),
        .i_res_data    (m_data),
        .i_res_user    (m_user),
        .i_res_last    (m_last),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    // The result side stalls now and then, except over a window of cycles where it is
    // always ready, so that back-to-back results get through at full rate too.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= 500 && cycle_count < 1100) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IdlePercent);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        while (cycle_count < CycleLimit) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function logic [7:0] punct_char(input int idx);
        case (idx)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_EQUAL;
            5:       return CH_LT;
            6:       return CH_GT;
            7:       return CH_LPAR;
            8:       return CH_RPAR;
            9:       return CH_LBRACE;
            10:      return CH_RBRACE;
            11:      return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    task push_char(input logic [7:0] c);
        char_items.insert(char_items.size(), {IK_CHAR, c});
    endtask

    // The byte beside an end-of-input mark is meant to be ignored, so it is random.
    task push_eof;
        char_items.insert(char_items.size(), {IK_EOF, 8'($urandom_range(255))});
    endtask

    initial begin
        int         len;
        int         sent;
        logic [7:0] quote;

        // Directed opening: each class, the boundaries between them, escapes inside a
        // quote, an unterminated quote at end of input and an end of input with nothing
        // pending.
        push_char(8'h61);        // word opens
        push_char(8'hFF);        // top byte continues the word
        push_char(CH_NINE);      // digit closes the word and opens a number
        push_char(CH_DOT);
        push_char(CH_ZERO);
        push_char(CH_PLUS);      // number closed, then an operator and its marker
        push_char(CH_LT);        // bracket or comparison
        push_char(8'h00);        // the zero byte is a word character
        push_char(CH_CR);        // carriage return closes the word
        push_char(CH_LF);        // whitespace with nothing pending gives nothing
        push_char(CH_SQUOTE);    // single quote opens
        push_char(CH_SPACE);     // space inside a quote is kept
        push_char(CH_BSLASH);
        push_char(CH_SQUOTE);    // escaped, so the quote stays open
        push_char(CH_SQUOTE);    // closes
        push_char(CH_DQUOTE);
        push_eof();              // unterminated double quote gets its marker
        push_eof();              // nothing pending
        push_char(CH_BTICK);
        push_char(CH_BTICK);     // empty back quoted string
        push_char(8'h78);
        push_char(CH_DQUOTE);    // word closed by an opening quote
        push_char(CH_DQUOTE);
        push_char(8'h35);
        push_eof();              // end of input closes a number

        // Random part: mostly well-formed tokens with random content, some noise.
        len = char_items.size() + RandomItems;
        while (char_items.size() < len) begin
            case ($urandom_range(14))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(6, 1)) begin
                        case ($urandom_range(3))
                            0:       push_char(8'h80 + 8'($urandom_range(127)));
                            1:       push_char($urandom_range(7) == 0 ? CH_BSLASH : 8'h09);
                            default: push_char(8'h61 + 8'($urandom_range(25)));
                        endcase
                    end
                end
                4, 5, 6: begin
                    repeat ($urandom_range(5, 1))
                        push_char($urandom_range(9) == 0 ? CH_DOT
                                                         : CH_ZERO + 8'($urandom_range(9)));
                end
                7, 8: push_char(punct_char($urandom_range(12)));
                9, 10: begin
                    case ($urandom_range(2))
                        0:       quote = CH_SQUOTE;
                        1:       quote = CH_DQUOTE;
                        default: quote = CH_BTICK;
                    endcase
                    push_char(quote);
                    repeat ($urandom_range(6)) begin
                        case ($urandom_range(4))
                            0:       push_char(CH_BSLASH);
                            1:       push_char(quote);
                            2:       push_char($urandom_range(1) ? CH_SPACE : CH_LF);
                            default: push_char(8'h20 + 8'($urandom_range(94)));
                        endcase
                    end
                    if ($urandom_range(9) == 0) begin
                        push_eof();
                    end else begin
                        push_char(quote);
                    end
                end
                11: begin
                    case ($urandom_range(2))
                        0:       push_char(CH_SPACE);
                        1:       push_char(CH_LF);
                        default: push_char(CH_CR);
                    endcase
                end
                12:      push_eof();
                default: push_char(8'($urandom_range(255)));
            endcase
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender: an item on offer is held until it is taken; gaps only fall between
        // items, and a run of items in the middle is sent without any gap.
        sent = 0;
        while (sent < char_items.size()) begin
            @(posedge i_clk);
            if (s_valid && s_ready) sent++;
            if (s_valid && !s_ready) begin
                // Still waiting for the item on offer to be taken.
            end else if (sent < char_items.size() &&
                         ((sent >= 200 && sent < 320) ||
                          $urandom_range(99) >= IdlePercent)) begin
                s_valid          <= 1'b1;
                {s_user, s_data} <= char_items[sent];
            end else begin
                s_valid <= 1'b0;
            end
        end

        // Wait for the checker's count to take in the last item, then drain.
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0 && results_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
